>>> hdl/raw_row_length_code_decoder_core_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef RAW_ROW_LENGTH_CODE_DECODER_CORE_MACROS_SVH
`define RAW_ROW_LENGTH_CODE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRLCD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RRLCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rrlcd_pkg.sv
package rrlcd_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0] pixel_t;
  typedef logic [13:0] column_t;
  typedef logic [3:0]  len_t;

  // Widest row the decoder honours; wider settings are clamped to it.
  localparam column_t MAX_ROW_WIDTH   = 14'd11976;
  localparam column_t ROW_WIDTH_RESET = 14'd8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // A length of this value means a raw 16-bit sample.
  localparam len_t LEN_RAW = 4'd14;

  typedef struct packed {
    word_t stream_word;
    logic  row_start;
  } word_item_t;

  typedef struct packed {
    logic       valid;
    word_item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [2:0] zeros;
    logic [2:0] used;
    logic       bit_b;
  } code_t;

  // Decodes one length code from the six bits at the head of the stream,
  // most significant first.
  function automatic code_t decode_code(input logic [5:0] bits);
    code_t c;
    c = '0;
    priority if (bits[5]) begin
      c.zeros = 3'd0;
      c.used  = 3'd1;
    end else if (bits[4]) begin
      c.zeros = 3'd1;
      c.used  = 3'd3;
      c.bit_b = bits[3];
    end else if (bits[3]) begin
      c.zeros = 3'd2;
      c.used  = 3'd4;
      c.bit_b = bits[2];
    end else if (bits[2]) begin
      c.zeros = 3'd3;
      c.used  = 3'd5;
      c.bit_b = bits[1];
    end else if (bits[1]) begin
      c.zeros = 3'd4;
      c.used  = 3'd6;
      c.bit_b = bits[0];
    end else begin
      c.zeros = 3'd5;
      c.used  = 3'd6;
      c.bit_b = bits[0];
    end
    return c;
  endfunction

  // Length table, indexed by zero count and the bit after the code.
  function automatic len_t code_length(input logic [2:0] zeros, input logic bit_b);
    len_t l;
    unique case ({zeros, bit_b})
      4'b0010: l = 4'd8;
      4'b0011: l = 4'd7;
      4'b0100: l = 4'd6;
      4'b0101: l = 4'd9;
      4'b0110: l = 4'd11;
      4'b0111: l = 4'd10;
      4'b1000: l = 4'd5;
      4'b1001: l = 4'd12;
      4'b1010: l = 4'd14;
      4'b1011: l = 4'd13;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

endpackage

>>> hdl/rrlcd_if.sv
interface rrlcd_word_if import rrlcd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t stream_word;
  logic  row_start;

  modport source (output valid, output stream_word, output row_start, input ready);
  modport sink   (input valid, input stream_word, input row_start, output ready);
endinterface

interface rrlcd_pixel_if import rrlcd_pkg::*; ();
  logic    valid;
  logic    ready;
  pixel_t  pixel;
  column_t column;
  logic    last_of_row;
  logic    corrupt;

  modport source (output valid, output pixel, output column, output last_of_row,
                  output corrupt, input ready);
  modport sink   (input valid, input pixel, input column, input last_of_row,
                  input corrupt, output ready);
endinterface

>>> hdl/rrlcd_front.sv
`include "raw_row_length_code_decoder_core_macros.svh"

module rrlcd_front import rrlcd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rrlcd_word_if.sink   word_i,
  input  logic         pop_i,
  output queue_head_t  head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  word_item_t            mem_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  push;

  assign word_i.ready = (count_q != CntW'(DEPTH));
  assign push         = word_i.valid && word_i.ready;

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{stream_word: word_i.stream_word, row_start: word_i.row_start};
    end
  end

  `RRLCD_ASSERT_IMPL(a_pop_not_empty, clk_i, rst_ni, pop_i, count_q != '0, "queue popped while empty")
  `RRLCD_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(DEPTH), "queue count beyond depth")

endmodule

>>> hdl/rrlcd_back.sv
`include "raw_row_length_code_decoder_core_macros.svh"

module rrlcd_back import rrlcd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  column_t       row_width_i,
  input  queue_head_t   head_i,
  output logic          pop_o,
  rrlcd_pixel_if.source pix_o
);

  logic [63:0]       buf_q, buf_d;
  logic [5:0]        held_q, held_d;
  logic [1:0][15:0]  pred_q, pred_d;
  logic [1:0][3:0]   len_q, len_d;
  column_t           col_q, col_d;
  logic              done_q, done_d;
  logic              codes_q, codes_d;

  logic              out_valid_q, out_valid_d;
  pixel_t            out_pixel_q, out_pixel_d;
  column_t           out_column_q, out_column_d;
  logic              out_last_q, out_last_d;
  logic              out_corrupt_q, out_corrupt_d;

  logic              busy, slot_free, past_end, need_codes, err, par, raw, is_last;
  logic              pix_load, err_load;
  column_t           width, coded_end, col_inc;
  logic [63:0]       shifted;
  logic [31:0]       win, win2;
  code_t             code0, code1;
  logic [3:0]        used_codes;
  len_t              cur_len;
  pixel_t            v16, diff_v, half, pix_val;
  logic [4:0]        used_pix;

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel       = out_pixel_q;
  assign pix_o.column      = out_column_q;
  assign pix_o.last_of_row = out_last_q;
  assign pix_o.corrupt     = out_corrupt_q;

  always_comb begin
    // A column whose codes have just been read still owes its pixel, even when
    // the codes left fewer than 32 bits in the buffer.
    busy       = !done_q && (held_q[5] || codes_q);
    pop_o      = !busy && head_i.valid;
    slot_free  = !out_valid_q || pix_o.ready;
    width      = (row_width_i > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : row_width_i;
    coded_end  = {width[13:3], 3'b000};
    // The next 32 stream bits, most significant first, zero filled when fewer
    // are held.
    shifted    = buf_q << (7'd64 - {1'b0, held_q});
    win        = shifted[63:32];
    past_end   = (col_q >= width);
    need_codes = (col_q < coded_end) && (col_q[2:0] == 3'b000) && !codes_q;
    code0      = decode_code(win[31:26]);
    win2       = win << code0.used;
    code1      = decode_code(win2[31:26]);
    err        = (col_q == '0) && ((code0.zeros == 3'd0) || (code1.zeros == 3'd0));
    used_codes = {1'b0, code0.used} + {1'b0, code1.used};
    par        = col_q[0];
    cur_len    = (col_q >= coded_end) ? LEN_RAW : len_q[par];
    raw        = (cur_len == LEN_RAW) || (cur_len == 4'd0);
    v16        = win[31:16];
    diff_v     = v16 >> (5'd16 - {1'b0, cur_len});
    half       = 16'd1 << (cur_len - 4'd1);
    pix_val    = raw ? v16 : pred_q[par] + diff_v + 16'd1 - half;
    used_pix   = raw ? 5'd16 : {1'b0, cur_len};
    col_inc    = col_q + 14'd1;
    is_last    = (col_inc == width);
    err_load   = busy && !past_end && need_codes && slot_free && err;
    pix_load   = busy && !past_end && !need_codes && slot_free;
  end

  always_comb begin
    buf_d         = buf_q;
    held_d        = held_q;
    pred_d        = pred_q;
    len_d         = len_q;
    col_d         = col_q;
    done_d        = done_q;
    codes_d       = codes_q;
    out_valid_d   = out_valid_q && !pix_o.ready;
    out_pixel_d   = out_pixel_q;
    out_column_d  = out_column_q;
    out_last_d    = out_last_q;
    out_corrupt_d = out_corrupt_q;

    if (pop_o) begin
      if (head_i.item.row_start) begin
        buf_d   = {32'd0, head_i.item.stream_word};
        held_d  = 6'd32;
        pred_d  = '0;
        len_d   = '0;
        col_d   = '0;
        done_d  = 1'b0;
        codes_d = 1'b0;
      end else if (!done_q) begin
        buf_d  = {buf_q[31:0], head_i.item.stream_word};
        held_d = held_q + 6'd32;
      end
    end else if (busy) begin
      priority if (past_end) begin
        done_d = 1'b1;
      end else if (need_codes) begin
        if (slot_free) begin
          if (err) begin
            out_valid_d   = 1'b1;
            out_pixel_d   = '0;
            out_column_d  = '0;
            out_last_d    = 1'b1;
            out_corrupt_d = 1'b1;
            done_d        = 1'b1;
          end else begin
            held_d  = held_q - {2'b00, used_codes};
            codes_d = 1'b1;
            if (code0.zeros != 3'd0) begin
              len_d[0] = code_length(code0.zeros, code0.bit_b);
            end
            if (code1.zeros != 3'd0) begin
              len_d[1] = code_length(code1.zeros, code1.bit_b);
            end
          end
        end
      end else begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_pixel_d   = pix_val;
          out_column_d  = col_q;
          out_last_d    = is_last;
          out_corrupt_d = 1'b0;
          pred_d[par]   = pix_val;
          held_d        = held_q - {1'b0, used_pix};
          col_d         = col_inc;
          codes_d       = 1'b0;
          if (is_last) begin
            done_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      col_q       <= '0;
      done_q      <= 1'b1;
      codes_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      col_q       <= col_d;
      done_q      <= done_d;
      codes_q     <= codes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q         <= buf_d;
    pred_q        <= pred_d;
    len_q         <= len_d;
    out_pixel_q   <= out_pixel_d;
    out_column_q  <= out_column_d;
    out_last_q    <= out_last_d;
    out_corrupt_q <= out_corrupt_d;
  end

  `RRLCD_ASSERT_IMPL(a_corrupt_shape, clk_i, rst_ni, out_valid_q && out_corrupt_q, out_last_q && (out_column_q == '0), "corrupt result not at column zero")
  `RRLCD_ASSERT_NEXT(a_row_closes, clk_i, rst_ni, err_load || (pix_load && is_last), done_q, "row not closed after its final result")
  `RRLCD_ASSERT_IMPL(a_pixel_in_row, clk_i, rst_ni, pix_load, (col_q < width) && (held_q[5] || codes_q), "pixel decoded outside the row or short of bits")

endmodule

>>> hdl/raw_row_length_code_decoder_core.sv
// Channel   Direction  Handshake     Payload
// word_i    in         valid/ready   stream_word[31:0], row_start
// pixel_o   out        valid/ready   pixel[15:0], column[13:0], last_of_row, corrupt
// cfg       in         cfg_we_i      cfg_wdata_i[13:0] (row width)
//
// A word moves from the queue into the bit buffer; the pixels are then decoded in turn,
// and each eighth coded column first reads its two codes.
// Reset empties the queue, the output register and the row position; the decoder then
// waits for a transaction with row_start set. There is no clearing pass.
// A stalled output holds the back end; the queue keeps taking transactions until full.

`include "raw_row_length_code_decoder_core_macros.svh"

module raw_row_length_code_decoder_core import rrlcd_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  column_t       cfg_wdata_i,
  rrlcd_word_if.sink    word_i,
  rrlcd_pixel_if.source pixel_o
);

  // The row width register. The user must write it only while the decoder is idle,
  // so the back end may read it directly at every column; the block does not enforce it.
  column_t     row_width_q, row_width_d;

  // Head of the word queue, handed from the front end to the back end.
  queue_head_t head;
  logic        pop;

  always_comb begin
    row_width_d = row_width_q;
    if (cfg_we_i) begin
      row_width_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
    end else begin
      row_width_q <= row_width_d;
    end
  end

  // The front end takes each transaction into a short queue, so that the
  // input side can run ahead of the pixel loop until the queue is full.
  rrlcd_front #(
    .DEPTH (QueueDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (word_i),
    .pop_i  (pop),
    .head_o (head)
  );

  // The back end owns the bit buffer, the predictors and the code lengths.
  // It pops a word whenever fewer than 32 bits are held and no column is still
  // owed its pixel after its codes were read, or when the row is closed; words
  // arriving for a closed row without row_start are dropped.
  rrlcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_width_i (row_width_q),
    .head_i      (head),
    .pop_o       (pop),
    .pix_o       (pixel_o)
  );

  // A popped word must always be a valid queue entry.
  `RRLCD_ASSERT_IMPL(a_pop_valid, clk_i, rst_ni, pop, head.valid, "word popped from an empty queue")

endmodule
